@@ hdl/particle_swarm_velocity_update_unit_assert.svh @@
// Assertion macros for the particle swarm velocity update unit.
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef PARTICLE_SWARM_VELOCITY_UPDATE_UNIT_ASSERT_SVH
`define PARTICLE_SWARM_VELOCITY_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define PSVU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psvu assertion failed");

// next-cycle implication
`define PSVU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psvu assertion failed");

`endif

@@ hdl/psvu_pkg.sv @@
// Shared constants, types and helpers of the particle swarm velocity update unit.
// No dependencies; used by psvu_div and the top level.
`timescale 1ns / 1ps

package psvu_pkg;

  localparam int VAL_W       = 32;
  localparam int COEF_W      = 16;
  localparam int SCALE_W     = 17;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 32;
  localparam int K_W         = 20;
  localparam int DELTA_W     = VAL_W + 1;
  localparam int PULL_W      = K_W + 1 + DELTA_W;
  localparam int PSUM_W      = PULL_W - 16 + 1;
  localparam int LPROD_W     = SCALE_W + VAL_W;
  localparam int DIV_STEPS   = 4;
  localparam int DIV_STAGES  = VAL_W / DIV_STEPS;
  localparam int CAR_DEPTH   = DIV_STAGES - 1;
  localparam int PIPE_DEPTH  = DIV_STAGES + 6;

  localparam logic [2:0] REG_INERTIA_START = 3'd0;
  localparam logic [2:0] REG_INERTIA_END   = 3'd1;
  localparam logic [2:0] REG_MAX_EPOCH     = 3'd2;
  localparam logic [2:0] REG_COGNITIVE     = 3'd3;
  localparam logic [2:0] REG_SOCIAL        = 3'd4;
  localparam logic [2:0] REG_VEL_SCALE     = 3'd5;

  localparam logic [COEF_W-1:0]  RST_INERTIA_START = 16'd16384;
  localparam logic [COEF_W-1:0]  RST_INERTIA_END   = 16'd6554;
  localparam logic [COEF_W-1:0]  RST_MAX_EPOCH     = 16'd100;
  localparam logic [COEF_W-1:0]  RST_COGNITIVE     = 16'd8192;
  localparam logic [COEF_W-1:0]  RST_SOCIAL        = 16'd8192;
  localparam logic [SCALE_W-1:0] RST_VEL_SCALE     = 17'd13107;
  localparam logic [SCALE_W-1:0] SCALE_ONE         = 17'd65536;

  localparam logic [1:0] HIT_NONE = 2'd0;
  localparam logic [1:0] HIT_MIN  = 2'd1;
  localparam logic [1:0] HIT_MAX  = 2'd2;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef struct packed {
    logic [COEF_W-1:0] rem;
    logic [VAL_W-1:0]  nq;
  } div_t;

  typedef struct packed {
    logic [VAL_W-1:0]          num;
    logic [COEF_W-1:0]         den;
    logic [K_W-1:0]            kc;
    logic [K_W-1:0]            ks;
    logic signed [DELTA_W-1:0] dp;
    logic signed [DELTA_W-1:0] dg;
    logic [VAL_W-1:0]          span;
    logic [SCALE_W-1:0]        scale;
    logic                      neg;
    logic signed [VAL_W-1:0]   pos;
    logic signed [VAL_W-1:0]   vel;
    logic signed [VAL_W-1:0]   lo;
    logic signed [VAL_W-1:0]   hi;
  } s1_t;

  typedef struct packed {
    logic signed [PULL_W-1:0] pc;
    logic signed [PULL_W-1:0] ps;
    logic [LPROD_W-1:0]       lp;
    logic                     neg;
    logic signed [VAL_W-1:0]  pos;
    logic signed [VAL_W-1:0]  vel;
    logic signed [VAL_W-1:0]  lo;
    logic signed [VAL_W-1:0]  hi;
  } s2_t;

  typedef struct packed {
    logic signed [PSUM_W-1:0] psum;
    logic [VAL_W-1:0]         lim;
    logic                     neg;
    logic signed [VAL_W-1:0]  pos;
    logic signed [VAL_W-1:0]  vel;
    logic signed [VAL_W-1:0]  lo;
    logic signed [VAL_W-1:0]  hi;
  } car_t;

  function automatic div_t div_step(input logic [COEF_W-1:0] d, input div_t s);
    div_t             r;
    logic [COEF_W:0]  t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t    = {r.rem, r.nq[VAL_W-1]};
      r.nq = {r.nq[VAL_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t       = t - {1'b0, d};
        r.nq[0] = 1'b1;
      end
      r.rem = t[COEF_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] neg_sat(input logic signed [VAL_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    r = (v == VAL_MIN) ? VAL_MAX : -v;
    return r;
  endfunction

endpackage

@@ hdl/psvu_div.sv @@
// Pipelined restoring divider, four quotient bits per stage.
// Depends on psvu_pkg (div_t, div_step, stage count).
`timescale 1ns / 1ps

module psvu_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [psvu_pkg::VAL_W-1:0]   num_i,
  input  logic [psvu_pkg::COEF_W-1:0]  den_i,
  output logic [psvu_pkg::VAL_W-1:0]   quo_o
);

  psvu_pkg::div_t              st_q  [psvu_pkg::DIV_STAGES];
  logic [psvu_pkg::COEF_W-1:0] den_q [psvu_pkg::DIV_STAGES];
  psvu_pkg::div_t              first_d;

  always_comb begin
    first_d.rem = '0;
    first_d.nq  = num_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]  <= psvu_pkg::div_step(den_i, first_d);
      den_q[0] <= den_i;
      for (int k = 1; k < psvu_pkg::DIV_STAGES; k++) begin
        st_q[k]  <= psvu_pkg::div_step(den_q[k-1], st_q[k-1]);
        den_q[k] <= den_q[k-1];
      end
    end
  end

  assign quo_o = st_q[psvu_pkg::DIV_STAGES-1].nq;

endmodule

@@ hdl/particle_swarm_velocity_update_unit.sv @@
// Throughput: one item per cycle while the output is not stalled; the 8-stage inertia divider sets the depth.
// in_ready_o drops only while a finished result waits on the output.
// Reset clears all valid bits and restores the configuration registers.
// Top level; depends on psvu_pkg, psvu_div and the assertion macro header.
`timescale 1ns / 1ps
`include "particle_swarm_velocity_update_unit_assert.svh"

module particle_swarm_velocity_update_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [psvu_pkg::ADDR_W-1:0]         paddr,
  input  logic [psvu_pkg::DATA_W-1:0]         pwdata,
  output logic [psvu_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [psvu_pkg::VAL_W-1:0]   position_i,
  input  logic signed [psvu_pkg::VAL_W-1:0]   velocity_i,
  input  logic signed [psvu_pkg::VAL_W-1:0]   personal_best_i,
  input  logic signed [psvu_pkg::VAL_W-1:0]   swarm_best_i,
  input  logic [psvu_pkg::COEF_W-1:0]         rand_cognitive_i,
  input  logic [psvu_pkg::COEF_W-1:0]         rand_social_i,
  input  logic signed [psvu_pkg::VAL_W-1:0]   dim_min_i,
  input  logic signed [psvu_pkg::VAL_W-1:0]   dim_max_i,
  input  logic [psvu_pkg::COEF_W-1:0]         epoch_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [psvu_pkg::VAL_W-1:0]   new_position_o,
  output logic signed [psvu_pkg::VAL_W-1:0]   new_velocity_o,
  output logic                                velocity_clamped_o,
  output logic [1:0]                          bound_hit_o
);

  localparam int VW = psvu_pkg::VAL_W;
  localparam int CW = psvu_pkg::COEF_W;

  logic [CW-1:0]                  inertia_start_q, inertia_end_q, max_epoch_q;
  logic [CW-1:0]                  cognitive_coeff_q, social_coeff_q;
  logic [psvu_pkg::SCALE_W-1:0]   vel_limit_scale_q;
  logic                           wr_en;

  logic [psvu_pkg::PIPE_DEPTH-1:0] vld_q;
  logic                            adv;

  psvu_pkg::s1_t  s1_d, s1_q;
  psvu_pkg::s2_t  s2_d, s2_q;
  psvu_pkg::car_t car0_d;
  psvu_pkg::car_t car_q [psvu_pkg::CAR_DEPTH];
  psvu_pkg::car_t car9, car10_q, car11_q;
  logic [VW-1:0]  quo;

  logic signed [CW:0]     rdiff;
  logic [2*CW-1:0]        kc_prod, ks_prod;
  logic signed [VW:0]     span_full;

  logic signed [VW+1:0]   w_full;
  logic [CW-1:0]          w10_d, w10_q;
  logic signed [CW+VW:0]  wv_prod;
  logic signed [VW+2:0]   wv11_d, wv11_q;
  logic signed [VW+7:0]   v12_d, v12_q, lim_s;
  logic signed [VW-1:0]   pos12_q, lo12_q, hi12_q;
  logic [VW-1:0]          lim12_q;
  logic signed [VW+7:0]   vcl;
  logic                   cl13_d, cl13_q;
  logic signed [VW-1:0]   vc13_d, vc13_q, pos13_q, lo13_q, hi13_q;
  logic [VW-1:0]          lim13_q;
  logic signed [VW:0]     p_sum;
  logic signed [VW-1:0]   pos14_d, pos14_q, vel14_d, vel14_q;
  logic [1:0]             hit14_d, hit14_q;
  logic                   cl14_q;

  // configuration port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inertia_start_q   <= psvu_pkg::RST_INERTIA_START;
      inertia_end_q     <= psvu_pkg::RST_INERTIA_END;
      max_epoch_q       <= psvu_pkg::RST_MAX_EPOCH;
      cognitive_coeff_q <= psvu_pkg::RST_COGNITIVE;
      social_coeff_q    <= psvu_pkg::RST_SOCIAL;
      vel_limit_scale_q <= psvu_pkg::RST_VEL_SCALE;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        psvu_pkg::REG_INERTIA_START: inertia_start_q   <= pwdata[CW-1:0];
        psvu_pkg::REG_INERTIA_END:   inertia_end_q     <= pwdata[CW-1:0];
        psvu_pkg::REG_MAX_EPOCH:     max_epoch_q       <= pwdata[CW-1:0];
        psvu_pkg::REG_COGNITIVE:     cognitive_coeff_q <= pwdata[CW-1:0];
        psvu_pkg::REG_SOCIAL:        social_coeff_q    <= pwdata[CW-1:0];
        psvu_pkg::REG_VEL_SCALE:     vel_limit_scale_q <= pwdata[psvu_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      psvu_pkg::REG_INERTIA_START: prdata = 32'(inertia_start_q);
      psvu_pkg::REG_INERTIA_END:   prdata = 32'(inertia_end_q);
      psvu_pkg::REG_MAX_EPOCH:     prdata = 32'(max_epoch_q);
      psvu_pkg::REG_COGNITIVE:     prdata = 32'(cognitive_coeff_q);
      psvu_pkg::REG_SOCIAL:        prdata = 32'(social_coeff_q);
      psvu_pkg::REG_VEL_SCALE:     prdata = 32'(vel_limit_scale_q);
      default:                     prdata = '0;
    endcase
  end

  // pipeline control: advance unless the output item is held
  assign adv         = !vld_q[psvu_pkg::PIPE_DEPTH-1] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[psvu_pkg::PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[psvu_pkg::PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  // stage 1: ramp numerator, random-weighted coefficients, deltas, range
  always_comb begin
    rdiff     = $signed({1'b0, inertia_end_q}) - $signed({1'b0, inertia_start_q});
    kc_prod   = 32'(cognitive_coeff_q) * 32'(rand_cognitive_i);
    ks_prod   = 32'(social_coeff_q) * 32'(rand_social_i);
    span_full = $signed({dim_max_i[VW-1], dim_max_i}) - $signed({dim_min_i[VW-1], dim_min_i});
    s1_d.neg  = rdiff[CW];
    s1_d.num  = 32'(s1_d.neg ? CW'(-rdiff) : rdiff[CW-1:0]) * 32'(epoch_i);
    s1_d.den  = (max_epoch_q == '0) ? CW'(1) : max_epoch_q;
    s1_d.kc   = kc_prod[2*CW-1:12];
    s1_d.ks   = ks_prod[2*CW-1:12];
    s1_d.dp   = $signed({personal_best_i[VW-1], personal_best_i})
              - $signed({position_i[VW-1], position_i});
    s1_d.dg   = $signed({swarm_best_i[VW-1], swarm_best_i})
              - $signed({position_i[VW-1], position_i});
    s1_d.span = (dim_max_i > dim_min_i) ? span_full[VW-1:0] : '0;
    s1_d.scale = (vel_limit_scale_q > psvu_pkg::SCALE_ONE) ? psvu_pkg::SCALE_ONE
                                                           : vel_limit_scale_q;
    s1_d.pos  = position_i;
    s1_d.vel  = velocity_i;
    s1_d.lo   = dim_min_i;
    s1_d.hi   = dim_max_i;
  end

  // stage 2: pull and limit products
  always_comb begin
    s2_d.pc  = psvu_pkg::PULL_W'($signed({1'b0, s1_q.kc}))
             * psvu_pkg::PULL_W'(s1_q.dp);
    s2_d.ps  = psvu_pkg::PULL_W'($signed({1'b0, s1_q.ks}))
             * psvu_pkg::PULL_W'(s1_q.dg);
    s2_d.lp  = psvu_pkg::LPROD_W'(s1_q.scale) * psvu_pkg::LPROD_W'(s1_q.span);
    s2_d.neg = s1_q.neg;
    s2_d.pos = s1_q.pos;
    s2_d.vel = s1_q.vel;
    s2_d.lo  = s1_q.lo;
    s2_d.hi  = s1_q.hi;
  end

  // stage 3: pull sum and velocity limit
  always_comb begin
    car0_d.psum = psvu_pkg::PSUM_W'(s2_q.pc >>> 16) + psvu_pkg::PSUM_W'(s2_q.ps >>> 16);
    car0_d.lim  = s2_q.lp[VW+15:16];
    car0_d.neg  = s2_q.neg;
    car0_d.pos  = s2_q.pos;
    car0_d.vel  = s2_q.vel;
    car0_d.lo   = s2_q.lo;
    car0_d.hi   = s2_q.hi;
  end

  psvu_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (s1_q.num),
    .den_i (s1_q.den),
    .quo_o (quo)
  );

  assign car9 = car_q[psvu_pkg::CAR_DEPTH-1];

  // stage 10: inertia weight, saturated
  always_comb begin
    w_full = $signed({2'b00, inertia_start_q})
           + (car9.neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo}));
    if (w_full < 0) begin
      w10_d = '0;
    end else if (w_full > $signed({{(VW-CW+2){1'b0}}, {CW{1'b1}}})) begin
      w10_d = '1;
    end else begin
      w10_d = w_full[CW-1:0];
    end
  end

  // stage 11: inertia term
  always_comb begin
    wv_prod = (CW+VW+1)'($signed({1'b0, w10_q})) * (CW+VW+1)'(car10_q.vel);
    wv11_d  = (VW+3)'(wv_prod >>> 14);
  end

  // stage 12: raw velocity
  assign v12_d = (VW+8)'(wv11_q) + (VW+8)'(car11_q.psum);

  // stage 13: clamp to the limit, then to the value range
  always_comb begin
    lim_s  = $signed({8'd0, lim12_q});
    vcl    = v12_q;
    cl13_d = 1'b0;
    if (v12_q > lim_s) begin
      vcl    = lim_s;
      cl13_d = 1'b1;
    end else if (v12_q < -lim_s) begin
      vcl    = -lim_s;
      cl13_d = 1'b1;
    end
    if (vcl > (VW+8)'(psvu_pkg::VAL_MAX)) begin
      vc13_d = psvu_pkg::VAL_MAX;
    end else if (vcl < (VW+8)'(psvu_pkg::VAL_MIN)) begin
      vc13_d = psvu_pkg::VAL_MIN;
    end else begin
      vc13_d = vcl[VW-1:0];
    end
  end

  // stage 14: integrate and reflect
  always_comb begin
    p_sum   = $signed({pos13_q[VW-1], pos13_q}) + $signed({vc13_q[VW-1], vc13_q});
    pos14_d = p_sum[VW-1:0];
    vel14_d = vc13_q;
    hit14_d = psvu_pkg::HIT_NONE;
    if (p_sum < $signed({lo13_q[VW-1], lo13_q})) begin
      pos14_d = lo13_q;
      vel14_d = psvu_pkg::neg_sat(vc13_q);
      hit14_d = psvu_pkg::HIT_MIN;
    end else if (p_sum > $signed({hi13_q[VW-1], hi13_q})) begin
      pos14_d = hi13_q;
      vel14_d = psvu_pkg::neg_sat(vc13_q);
      hit14_d = psvu_pkg::HIT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      car_q[0] <= car0_d;
      for (int k = 1; k < psvu_pkg::CAR_DEPTH; k++) begin
        car_q[k] <= car_q[k-1];
      end
      car10_q  <= car9;
      w10_q    <= w10_d;
      car11_q  <= car10_q;
      wv11_q   <= wv11_d;
      v12_q    <= v12_d;
      pos12_q  <= car11_q.pos;
      lo12_q   <= car11_q.lo;
      hi12_q   <= car11_q.hi;
      lim12_q  <= car11_q.lim;
      vc13_q   <= vc13_d;
      cl13_q   <= cl13_d;
      pos13_q  <= pos12_q;
      lo13_q   <= lo12_q;
      hi13_q   <= hi12_q;
      lim13_q  <= lim12_q;
      pos14_q  <= pos14_d;
      vel14_q  <= vel14_d;
      hit14_q  <= hit14_d;
      cl14_q   <= cl13_q;
    end
  end

  assign new_position_o     = pos14_q;
  assign new_velocity_o     = vel14_q;
  assign velocity_clamped_o = cl14_q;
  assign bound_hit_o        = hit14_q;

  `PSVU_ASSERT_NEXT(a_stall_freezes, out_valid_o && !out_ready_i, $stable(vld_q))
  `PSVU_ASSERT_NEXT(a_drain_refills, out_valid_o && out_ready_i && vld_q[psvu_pkg::PIPE_DEPTH-2], out_valid_o)
  `PSVU_ASSERT_NOW(a_clamp_at_limit, vld_q[psvu_pkg::PIPE_DEPTH-2] && cl13_q, lim13_q[VW-1] || $signed({1'b0, lim13_q}) == $signed({vc13_q[VW-1], vc13_q}) || $signed({1'b0, lim13_q}) == -$signed({vc13_q[VW-1], vc13_q}))

endmodule

@@ bench/particle_swarm_velocity_update_unit_tb.sv @@
// Self-checking bench for the particle swarm velocity update unit: directed and random items,
// predicted results held in a scoreboard. Needs psvu_pkg and the unit's RTL.
`timescale 1ns / 1ps

module particle_swarm_velocity_update_unit_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int ONE = 1 << 16;
  localparam int unsigned COEF_TOP = (1 << psvu_pkg::COEF_W) - 1;
  localparam int unsigned SCALE_TOP = (1 << psvu_pkg::SCALE_W) - 1;
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CFG_MIN = 0;
  localparam int CFG_MAX = 1;
  localparam int CFG_MIXED = 2;

  typedef struct packed {
    logic signed [psvu_pkg::VAL_W-1:0] position;
    logic signed [psvu_pkg::VAL_W-1:0] velocity;
    logic signed [psvu_pkg::VAL_W-1:0] personal_best;
    logic signed [psvu_pkg::VAL_W-1:0] swarm_best;
    logic [psvu_pkg::COEF_W-1:0]       rand_cognitive;
    logic [psvu_pkg::COEF_W-1:0]       rand_social;
    logic signed [psvu_pkg::VAL_W-1:0] dim_min;
    logic signed [psvu_pkg::VAL_W-1:0] dim_max;
    logic [psvu_pkg::COEF_W-1:0]       epoch;
  } coord_t;

  typedef struct packed {
    logic signed [psvu_pkg::VAL_W-1:0] new_position;
    logic signed [psvu_pkg::VAL_W-1:0] new_velocity;
    logic                              velocity_clamped;
    logic [1:0]                        bound_hit;
  } update_t;

  class swarm_scoreboard;
    logic [psvu_pkg::COEF_W-1:0]  inertia_start;
    logic [psvu_pkg::COEF_W-1:0]  inertia_end;
    logic [psvu_pkg::COEF_W-1:0]  max_epoch;
    logic [psvu_pkg::COEF_W-1:0]  cognitive;
    logic [psvu_pkg::COEF_W-1:0]  social;
    logic [psvu_pkg::SCALE_W-1:0] vel_scale;
    update_t                      pending_updates[$];
    int                           failures;

    function new();
      inertia_start = psvu_pkg::RST_INERTIA_START;
      inertia_end   = psvu_pkg::RST_INERTIA_END;
      max_epoch     = psvu_pkg::RST_MAX_EPOCH;
      cognitive     = psvu_pkg::RST_COGNITIVE;
      social        = psvu_pkg::RST_SOCIAL;
      vel_scale     = psvu_pkg::RST_VEL_SCALE;
      failures      = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [psvu_pkg::DATA_W-1:0] val);
      case (idx)
        psvu_pkg::REG_INERTIA_START: inertia_start = val[psvu_pkg::COEF_W-1:0];
        psvu_pkg::REG_INERTIA_END:   inertia_end = val[psvu_pkg::COEF_W-1:0];
        psvu_pkg::REG_MAX_EPOCH:     max_epoch = val[psvu_pkg::COEF_W-1:0];
        psvu_pkg::REG_COGNITIVE:     cognitive = val[psvu_pkg::COEF_W-1:0];
        psvu_pkg::REG_SOCIAL:        social = val[psvu_pkg::COEF_W-1:0];
        psvu_pkg::REG_VEL_SCALE:     vel_scale = val[psvu_pkg::SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function longint saturate(longint x);
      if (x > longint'(psvu_pkg::VAL_MAX)) return longint'(psvu_pkg::VAL_MAX);
      if (x < longint'(psvu_pkg::VAL_MIN)) return longint'(psvu_pkg::VAL_MIN);
      return x;
    endfunction

    function update_t update_coordinate(coord_t c);
      longint  pos, vel, lo, hi, ramp, w, kc, ks, v, sc, span, lim, p;
      update_t r;
      pos = $signed(c.position);
      vel = $signed(c.velocity);
      lo = $signed(c.dim_min);
      hi = $signed(c.dim_max);
      ramp = (max_epoch == '0) ? 64'sd1 : longint'(max_epoch);
      w = longint'(inertia_start)
          + (longint'(inertia_end) - longint'(inertia_start)) * longint'(c.epoch) / ramp;
      if (w < 0) w = 0;
      if (w > longint'(COEF_TOP)) w = longint'(COEF_TOP);
      kc = (longint'(cognitive) * longint'(c.rand_cognitive)) >>> 12;
      ks = (longint'(social) * longint'(c.rand_social)) >>> 12;
      v = ((w * vel) >>> 14)
          + ((kc * (longint'($signed(c.personal_best)) - pos)) >>> 16)
          + ((ks * (longint'($signed(c.swarm_best)) - pos)) >>> 16);
      sc = (vel_scale > psvu_pkg::SCALE_ONE) ? longint'(psvu_pkg::SCALE_ONE)
                                             : longint'(vel_scale);
      span = (hi > lo) ? hi - lo : 64'sd0;
      lim = (sc * span) >>> 16;
      r.velocity_clamped = 1'b0;
      r.bound_hit = psvu_pkg::HIT_NONE;
      if (v > lim) begin
        v = lim;
        r.velocity_clamped = 1'b1;
      end else if (v < -lim) begin
        v = -lim;
        r.velocity_clamped = 1'b1;
      end
      v = saturate(v);
      p = pos + v;
      if (p < lo) begin
        p = lo;
        v = saturate(-v);
        r.bound_hit = psvu_pkg::HIT_MIN;
      end else if (p > hi) begin
        p = hi;
        v = saturate(-v);
        r.bound_hit = psvu_pkg::HIT_MAX;
      end
      r.new_position = p[psvu_pkg::VAL_W-1:0];
      r.new_velocity = v[psvu_pkg::VAL_W-1:0];
      return r;
    endfunction

    function void note_item(coord_t c);
      pending_updates.insert(pending_updates.size(), update_coordinate(c));
    endfunction

    function void check_result(update_t got);
      update_t exp;
      if (pending_updates.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp = pending_updates.pop_front();
      if (got !== exp) begin
        failures++;
        if (got.new_position !== exp.new_position)
          $display("%0t: new_position expected %0d actual %0d", $time,
                   exp.new_position, got.new_position);
        if (got.new_velocity !== exp.new_velocity)
          $display("%0t: new_velocity expected %0d actual %0d", $time,
                   exp.new_velocity, got.new_velocity);
        if (got.velocity_clamped !== exp.velocity_clamped)
          $display("%0t: velocity_clamped expected %b actual %b", $time,
                   exp.velocity_clamped, got.velocity_clamped);
        if (got.bound_hit !== exp.bound_hit)
          $display("%0t: bound_hit expected %0d actual %0d", $time,
                   exp.bound_hit, got.bound_hit);
      end
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [psvu_pkg::ADDR_W-1:0]       paddr = '0;
  logic [psvu_pkg::DATA_W-1:0]       pwdata = '0;
  logic [psvu_pkg::DATA_W-1:0]       prdata;
  logic                              pready;
  logic                              in_valid = 1'b0;
  logic                              in_ready_o;
  coord_t                            cur = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [psvu_pkg::VAL_W-1:0] new_position_o;
  logic signed [psvu_pkg::VAL_W-1:0] new_velocity_o;
  logic                              velocity_clamped_o;
  logic [1:0]                        bound_hit_o;
  int                                idle_pct = 8;
  int                                quiet_cycles = 0;
  swarm_scoreboard                   sb;

  particle_swarm_velocity_update_unit uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .position_i         (cur.position),
    .velocity_i         (cur.velocity),
    .personal_best_i    (cur.personal_best),
    .swarm_best_i       (cur.swarm_best),
    .rand_cognitive_i   (cur.rand_cognitive),
    .rand_social_i      (cur.rand_social),
    .dim_min_i          (cur.dim_min),
    .dim_max_i          (cur.dim_max),
    .epoch_i            (cur.epoch),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .new_position_o     (new_position_o),
    .new_velocity_o     (new_velocity_o),
    .velocity_clamped_o (velocity_clamped_o),
    .bound_hit_o        (bound_hit_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready_o) sb.note_item(cur);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({new_position_o, new_velocity_o, velocity_clamped_o, bound_hit_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic coord_t coord(int p, int v, int pb, int gb, int rc, int rs,
                                   int lo, int hi, int ep);
    coord_t c;
    c.position = p;
    c.velocity = v;
    c.personal_best = pb;
    c.swarm_best = gb;
    c.rand_cognitive = rc[psvu_pkg::COEF_W-1:0];
    c.rand_social = rs[psvu_pkg::COEF_W-1:0];
    c.dim_min = lo;
    c.dim_max = hi;
    c.epoch = ep[psvu_pkg::COEF_W-1:0];
    return c;
  endfunction

  function automatic coord_t random_coord();
    coord_t c;
    int     lo;
    int     span;
    c.position = $urandom;
    c.velocity = $urandom;
    c.personal_best = $urandom;
    c.swarm_best = $urandom;
    c.rand_cognitive = psvu_pkg::COEF_W'($urandom);
    c.rand_social = psvu_pkg::COEF_W'($urandom);
    c.dim_min = $urandom;
    c.dim_max = $urandom;
    c.epoch = psvu_pkg::COEF_W'($urandom);
    if ($urandom_range(0, 99) < 50) c.epoch = psvu_pkg::COEF_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 75) begin
      lo = $signed($urandom) >>> $urandom_range(2, 16);
      span = $urandom >> $urandom_range(2, 31);
      c.dim_min = lo;
      c.dim_max = lo + span;
      c.position = lo + $urandom_range(0, span);
      c.personal_best = lo + $urandom_range(0, span);
      c.swarm_best = lo + $urandom_range(0, span);
      c.velocity = $signed($urandom) >>> $urandom_range(0, 31);
    end
    return c;
  endfunction

  function automatic logic [psvu_pkg::DATA_W-1:0] pick_value(int mode, int unsigned top,
                                                             int unsigned ceiling);
    if (mode == CFG_MIN) return 1;
    if (mode == CFG_MAX) return top;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return top;
      3: return ceiling;
      default: return $urandom_range(0, ceiling);
    endcase
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [psvu_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(idx, val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_registers(input int mode);
    apb_write(psvu_pkg::REG_INERTIA_START, pick_value(mode, COEF_TOP, COEF_TOP));
    apb_write(psvu_pkg::REG_INERTIA_END, pick_value(mode, COEF_TOP, COEF_TOP));
    apb_write(psvu_pkg::REG_MAX_EPOCH, pick_value(mode, COEF_TOP, COEF_TOP));
    apb_write(psvu_pkg::REG_COGNITIVE, pick_value(mode, COEF_TOP, COEF_TOP));
    apb_write(psvu_pkg::REG_SOCIAL, pick_value(mode, COEF_TOP, COEF_TOP));
    apb_write(psvu_pkg::REG_VEL_SCALE, pick_value(mode, psvu_pkg::SCALE_ONE, SCALE_TOP));
  endtask

  task automatic send_coord(input coord_t c);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    cur <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until every predicted update has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_updates.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_coord(coord(0, 0, 0, 0, 0, 0, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, 0));
    send_coord(coord(psvu_pkg::VAL_MAX, psvu_pkg::VAL_MAX, psvu_pkg::VAL_MIN,
                     psvu_pkg::VAL_MIN, COEF_TOP, COEF_TOP,
                     psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, COEF_TOP));
    send_coord(coord(psvu_pkg::VAL_MIN, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX,
                     psvu_pkg::VAL_MAX, COEF_TOP, COEF_TOP,
                     psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, COEF_TOP));
    send_coord(coord(psvu_pkg::VAL_MAX, psvu_pkg::VAL_MAX, psvu_pkg::VAL_MAX,
                     psvu_pkg::VAL_MAX, 0, 0, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, 50));
    send_coord(coord(psvu_pkg::VAL_MIN, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MIN,
                     psvu_pkg::VAL_MIN, 0, 0, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, 50));
    send_coord(coord(-1, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MIN,
                     COEF_TOP, COEF_TOP, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, 0));
    send_coord(coord(0, 32'sh30000000, 0, 0, 0, 0, psvu_pkg::VAL_MIN, psvu_pkg::VAL_MAX, 0));
    send_coord(coord(0, ONE, 3 * ONE, -3 * ONE, 16'h8000, 16'h8000, ONE, -ONE, 10));
    send_coord(coord(5 * ONE, ONE, 0, 9 * ONE, 16'h4000, 16'hC000, 5 * ONE, 5 * ONE, 20));
    send_coord(coord(-100 * ONE, 0, 0, 0, 0, 0, -10 * ONE, 10 * ONE, 0));
    send_coord(coord(0, 0, 1000 * ONE, 1000 * ONE, COEF_TOP, COEF_TOP, -ONE, ONE, 0));
    send_coord(coord(0, 0, -1000 * ONE, -1000 * ONE, COEF_TOP, COEF_TOP, -ONE, ONE, 0));
    send_coord(coord(ONE, 2 * ONE, -ONE, ONE, 16'h1234, 16'hFEDC, -50 * ONE, 50 * ONE, 1000));
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    settle();
    apb_write(psvu_pkg::REG_INERTIA_START, COEF_TOP);
    apb_write(psvu_pkg::REG_INERTIA_END, 0);
    apb_write(psvu_pkg::REG_MAX_EPOCH, 0);
    apb_write(psvu_pkg::REG_COGNITIVE, COEF_TOP);
    apb_write(psvu_pkg::REG_SOCIAL, COEF_TOP);
    apb_write(psvu_pkg::REG_VEL_SCALE, SCALE_TOP);
    apb_write(REG_UNUSED, '1);
    run_directed();
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      program_registers(ph == 0 ? CFG_MIN : (ph == 1 ? CFG_MAX : CFG_MIXED));
      idle_pct = (ph == 3) ? 0 : 8;
      repeat (200) send_coord(random_coord());
    end
    settle();
    repeat (30) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/psvu_pkg.sv
hdl/psvu_div.sv
hdl/particle_swarm_velocity_update_unit.sv
bench/particle_swarm_velocity_update_unit_tb.sv
